@@ src/ground_segment_projection_core_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef GROUND_SEGMENT_PROJECTION_CORE_MACROS_SVH
`define GROUND_SEGMENT_PROJECTION_CORE_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define GSP_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the same cycle.
`define GSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ src/gsp_pkg.sv @@
`timescale 1ns / 1ps
package gsp_pkg;

    localparam int COEF_W  = 20;
    localparam int PNT_W   = 25;
    localparam int PROD_W  = 45;
    localparam int DOT_W   = 48;
    localparam int WIDE_W  = 64;
    localparam int QUOT_W  = 16;
    localparam int LIM_W   = 19;
    localparam int CFG_W   = 60;
    localparam int IDX_W   = 3;
    localparam int HEIGHT_SHIFT = 10;

    // Divider: operand prep, one stage per quotient bit, rounding, saturation.
    localparam int DIV_LAT = QUOT_W + 3;
    localparam int FRONT_LAT = 4;
    localparam int LATENCY = FRONT_LAT + DIV_LAT;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 19'd51200;

    localparam logic [IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd4;

    function automatic logic signed [COEF_W-1:0] field20(input logic [CFG_W-1:0] packed_val,
                                                         input int col);
        return packed_val[col*COEF_W +: COEF_W];
    endfunction

endpackage

@@ src/gsp_div.sv @@
`timescale 1ns / 1ps
module gsp_div (
    input  logic                                  i_clk,
    input  logic signed [gsp_pkg::DOT_W-1:0]      i_num,
    input  logic        [gsp_pkg::DOT_W-1:0]      i_den,
    output logic signed [gsp_pkg::QUOT_W-1:0]     o_quot
);
    localparam int QW = gsp_pkg::QUOT_W;
    localparam int WW = gsp_pkg::WIDE_W;
    localparam int DW = gsp_pkg::DOT_W;

    logic [WW-1:0] r_rem [0:QW];
    logic [WW-1:0] r_den [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic          r_ovf [0:QW];

    logic [DW-1:0] mag;
    logic [WW-1:0] n_rem0;
    logic [WW-1:0] n_den0;
    logic          n_ovf0;

    always_comb begin
        mag    = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
        n_rem0 = WW'(mag);
        n_den0 = WW'(i_den);
        // A quotient of 2^16 or more saturates whatever the rounding.
        n_ovf0 = n_rem0 >= (n_den0 << QW);
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_den[0] <= n_den0;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[DW-1];
        r_ovf[0] <= n_ovf0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [WW-1:0] sh;
        logic [WW-1:0] n_rem;
        logic [QW-1:0] n_q;
        always_comb begin
            sh    = r_den[k] << (QW - 1 - k);
            n_rem = r_rem[k];
            n_q   = r_q[k];
            if (r_rem[k] >= sh) begin
                n_rem = r_rem[k] - sh;
                n_q[QW-1-k] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= n_q;
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    logic [WW-1:0] two_r;
    logic          round_up;
    logic [QW:0]   n_qr;
    logic [QW:0]   r_qr;
    logic          r_neg_rd;
    logic          r_ovf_rd;

    always_comb begin
        two_r    = r_rem[QW] << 1;
        round_up = (two_r > r_den[QW]) || ((two_r == r_den[QW]) && r_q[QW][0]);
        n_qr     = {1'b0, r_q[QW]} + (QW+1)'(round_up);
    end

    always_ff @(posedge i_clk) begin
        r_qr     <= n_qr;
        r_neg_rd <= r_neg[QW];
        r_ovf_rd <= r_ovf[QW];
    end

    logic signed [QW-1:0] n_out;
    logic signed [QW-1:0] r_out;

    always_comb begin
        if (r_neg_rd) begin
            if (r_ovf_rd || (r_qr > (QW+1)'(1 << (QW-1)))) begin
                n_out = {1'b1, {(QW-1){1'b0}}};
            end else begin
                n_out = QW'(-r_qr);
            end
        end else begin
            if (r_ovf_rd || (r_qr > (QW+1)'((1 << (QW-1)) - 1))) begin
                n_out = {1'b0, {(QW-1){1'b1}}};
            end else begin
                n_out = QW'(r_qr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_quot = r_out;

endmodule

@@ src/ground_segment_projection_core.sv @@
`timescale 1ns / 1ps
// Projects one ground point per clock into a vertical image segment. A point
// is taken whenever i_start is high (o_busy stays low), and its result, if
// the point passes the depth checks, appears on the o_ ports for one cycle
// with o_valid, after registered stages of offset add, multiply, dot-product
// sums and height add with depth checks, then a divider pipeline resolving
// one quotient bit per stage. Rejected points produce no beat. The receiver
// cannot stall the outputs. Configuration must be written while no point is
// in flight; the block does not enforce this. o_cfg_ready is always high.
module ground_segment_projection_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [23:0]                 i_ground_x,
    input  logic signed [23:0]                 i_ground_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gsp_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [gsp_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                               o_valid,
    output logic signed [15:0]                 o_top_u,
    output logic signed [15:0]                 o_top_v,
    output logic signed [15:0]                 o_base_u,
    output logic signed [15:0]                 o_base_v
);
    localparam int PW = gsp_pkg::PNT_W;
    localparam int DW = gsp_pkg::DOT_W;
    localparam int LAT = gsp_pkg::LATENCY;

    logic [gsp_pkg::CFG_W-1:0] r_row [0:2];
    logic [gsp_pkg::CFG_W-1:0] r_off;
    logic [gsp_pkg::LIM_W-1:0] r_lim;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_off    <= '0;
            r_lim    <= gsp_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsp_pkg::REG_ROW0:   r_row[0] <= i_cfg_data;
                gsp_pkg::REG_ROW1:   r_row[1] <= i_cfg_data;
                gsp_pkg::REG_ROW2:   r_row[2] <= i_cfg_data;
                gsp_pkg::REG_OFFSET: r_off    <= i_cfg_data;
                gsp_pkg::REG_LIMIT:  r_lim    <= i_cfg_data[gsp_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_vld [0:LAT-1];

    // Stage 1: shift the point by the camera offset.
    logic signed [PW-1:0] r_pnt [0:2];
    always_ff @(posedge i_clk) begin
        r_pnt[0] <= PW'(i_ground_x) + PW'(gsp_pkg::field20(r_off, 0));
        r_pnt[1] <= PW'(gsp_pkg::field20(r_off, 1));
        r_pnt[2] <= PW'(gsp_pkg::field20(r_off, 2)) - PW'(i_ground_y);
    end

    // Stage 2: nine coefficient products of the base point.
    logic signed [gsp_pkg::PROD_W-1:0] r_prod [0:2][0:2];
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            always_ff @(posedge i_clk) begin
                r_prod[r][c] <= gsp_pkg::field20(r_row[r], c) * r_pnt[c];
            end
        end
    end

    // Stage 3: base dot products.
    logic signed [DW-1:0] r_dot [0:2];
    for (genvar r = 0; r < 3; r++) begin : g_sum
        always_ff @(posedge i_clk) begin
            r_dot[r] <= DW'(r_prod[r][0]) + DW'(r_prod[r][1]) + DW'(r_prod[r][2]);
        end
    end

    // Stage 4: the raised end adds column 1 times the height, then depth checks.
    logic signed [DW-1:0] top [0:2];
    logic signed [DW-1:0] lim_q16;
    logic                 pass;
    logic signed [DW-1:0] r_top [0:2];
    logic signed [DW-1:0] r_base [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            top[r] = r_dot[r] +
                     (DW'(gsp_pkg::field20(r_row[r], 1)) <<< gsp_pkg::HEIGHT_SHIFT);
        end
        lim_q16 = DW'({r_lim, 8'b0});
        pass = (top[2] > 0) && (r_dot[2] > 0) && (top[2] <= lim_q16);
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_top[r]  <= top[r];
            r_base[r] <= r_dot[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_start;
            r_vld[1] <= r_vld[0];
            r_vld[2] <= r_vld[1];
            r_vld[3] <= r_vld[2] && pass;
            for (int s = 4; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    gsp_div u_div_tu (
        .i_clk  (i_clk),
        .i_num  (r_top[0]),
        .i_den  (DW'(r_top[2])),
        .o_quot (o_top_u)
    );

    gsp_div u_div_tv (
        .i_clk  (i_clk),
        .i_num  (r_top[1]),
        .i_den  (DW'(r_top[2])),
        .o_quot (o_top_v)
    );

    gsp_div u_div_bu (
        .i_clk  (i_clk),
        .i_num  (r_base[0]),
        .i_den  (DW'(r_base[2])),
        .o_quot (o_base_u)
    );

    gsp_div u_div_bv (
        .i_clk  (i_clk),
        .i_num  (r_base[1]),
        .i_den  (DW'(r_base[2])),
        .o_quot (o_base_v)
    );

    assign o_valid = r_vld[LAT-1];

endmodule

@@ src/gsp_checker.sv @@
`timescale 1ns / 1ps
`include "ground_segment_projection_core_macros.svh"
module gsp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic o_valid
);

    // Every result beat traces back to an earlier accepted point.
    `GSP_ASSERT_IMPLY(a_result_has_item, i_clk, i_rst_n, o_valid, $past(i_start && !o_busy, gsp_pkg::LATENCY))
    `GSP_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !o_busy)
    `GSP_ASSERT_ALWAYS(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready)
    // A configuration beat is only legal when nothing is in flight; the assertion only checks that o_valid is low.
    `GSP_ASSERT_IMPLY(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !o_valid)

endmodule

bind ground_segment_projection_core gsp_checker u_gsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .o_valid     (o_valid)
);
